// File: rtl/core/clock_mult_shift_calc_defines.svh
// Assertion macros shared by the clock scale calculator RTL.
`ifndef CLOCK_MULT_SHIFT_CALC_DEFINES_SVH
`define CLOCK_MULT_SHIFT_CALC_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CMSC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmsc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CMSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmsc: next-cycle check failed");

`endif

// File: rtl/core/cmsc_pkg.sv
// Types and constants of the clock scale calculator.
package cmsc_pkg;

   // Nanoseconds per second, 30 bits wide.
   localparam int unsigned NS_W = 30;
   localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

   // Largest shift tried and widths of the fixed result fields.
   localparam int unsigned SHIFT_W   = 6;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd63;
   localparam int unsigned MULT_W    = 32;

   // Numerator 10^9 << 63 needs 93 bits.
   localparam int unsigned NUM_W = NS_W + 63;
   localparam int unsigned CNT_W = $clog2(NUM_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

// File: rtl/core/clock_mult_shift_calc.sv
// Clock scale calculator: frequency in hertz to (mult, shift) for cycle-to-ns conversion.
//
// A transaction on req_ carries a counter frequency; one transaction comes back on rsp_
// with scale_mult and scale_shift such that ns = (cycles * scale_mult) >> scale_shift,
// where scale_shift is the largest shift up to 63 whose multiplier
// floor((10^9 << shift) / freq) still fits in 32 bits, and scale_mult is that multiplier
// (at least 1). A zero frequency returns active low with both fields zero.
// One shared subtractor does all the wide arithmetic under a small sequencer. First it
// searches the shift, one trial per cycle: shift s overflows exactly when
// 10^9 << s >= freq << 32, so each trial is one wide compare. Then it runs a restoring
// division of 10^9 << shift by freq, one numerator bit per cycle over all 93 bits.
// After acceptance the search tries shifts from 1 up to the first one that overflows
// (or up to 63), the division follows, and the result register then loads; a zero
// frequency skips both. req_stall stays high while an item is in work.
// The result register frees the engine, so a new request can be taken while an
// earlier result still waits on rsp_stall.
`include "clock_mult_shift_calc_defines.svh"

module clock_mult_shift_calc #(
   parameter int unsigned FREQ_WIDTH = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [FREQ_WIDTH-1:0]                req_freq_hz,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_active,
   output logic [cmsc_pkg::MULT_W-1:0]          rsp_scale_mult,
   output logic [cmsc_pkg::SHIFT_W-1:0]         rsp_scale_shift
);

   // Width of the shared subtractor: covers the numerator and freq << 32.
   localparam int unsigned FW = FREQ_WIDTH;
   localparam int unsigned CW = ((FW + cmsc_pkg::MULT_W) > cmsc_pkg::NUM_W) ?
                                (FW + cmsc_pkg::MULT_W) : cmsc_pkg::NUM_W;
   localparam int unsigned NW = cmsc_pkg::NUM_W;
   localparam int unsigned QW = cmsc_pkg::MULT_W;
   localparam int unsigned SW = cmsc_pkg::SHIFT_W;

   cmsc_pkg::state_type state_ff, state_in;

   logic [FW-1:0]              freq_ff,  freq_in;
   logic                       zero_ff,  zero_in;
   logic [NW-1:0]              num_ff,   num_in;    // numerator, MSB feeds the divider
   logic [FW-1:0]              rem_ff,   rem_in;    // partial remainder, below freq during division
   logic [QW-1:0]              quot_ff,  quot_in;
   logic [SW-1:0]              shift_ff, shift_in;
   logic [cmsc_pkg::CNT_W-1:0] cnt_ff,   cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_active_ff, rsp_active_in;
   logic [QW-1:0]              rsp_mult_ff,  rsp_mult_in;
   logic [SW-1:0]              rsp_shift_ff, rsp_shift_in;

   logic          req_accept;
   logic          rsp_load;
   logic [FW:0]   rem_sh;
   logic [CW-1:0] op_a;
   logic [CW-1:0] op_b;
   logic [CW:0]   diff;
   logic          ge;
   logic          last_step;

   assign req_stall  = (state_ff != cmsc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Result register can take a new value when empty or draining this cycle.
   assign rsp_load = (state_ff == cmsc_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign last_step = (cnt_ff == cmsc_pkg::CNT_W'(NW - 1));

   // Shared subtractor: search compares numerator to freq << 32,
   // division compares shifted remainder to freq.
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign op_a   = (state_ff == cmsc_pkg::ST_SEARCH) ? CW'(num_ff) : CW'(rem_sh);
   assign op_b   = (state_ff == cmsc_pkg::ST_SEARCH) ? CW'({freq_ff, {QW{1'b0}}})
                                                     : CW'(freq_ff);
   assign diff   = {1'b0, op_a} - {1'b0, op_b};
   assign ge     = ~diff[CW];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmsc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_freq_hz == '0) ? cmsc_pkg::ST_DONE : cmsc_pkg::ST_SEARCH;
            end
         end
         cmsc_pkg::ST_SEARCH: begin
            // Stop at the first overflowing shift, or when the last shift fits.
            if (ge || (shift_ff == cmsc_pkg::SHIFT_MAX)) begin
               state_in = cmsc_pkg::ST_DIVIDE;
            end
         end
         cmsc_pkg::ST_DIVIDE: begin
            if (last_step) begin
               state_in = cmsc_pkg::ST_DONE;
            end
         end
         cmsc_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = cmsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmsc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and result register.
   always_comb begin
      freq_in       = freq_ff;
      zero_in       = zero_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_active_in = rsp_active_ff;
      rsp_mult_in   = rsp_mult_ff;
      rsp_shift_in  = rsp_shift_ff;
      case (state_ff)
         cmsc_pkg::ST_IDLE: begin
            if (req_accept) begin
               freq_in  = req_freq_hz;
               zero_in  = (req_freq_hz == '0);
               num_in   = NW'(cmsc_pkg::NS_PER_SEC) << 1;
               rem_in   = '0;
               quot_in  = '0;
               shift_in = SW'(1);
               cnt_in   = '0;
            end
         end
         cmsc_pkg::ST_SEARCH: begin
            if (ge) begin
               // Overflow: step back one shift.
               shift_in = shift_ff - SW'(1);
               num_in   = num_ff >> 1;
            end else if (shift_ff != cmsc_pkg::SHIFT_MAX) begin
               shift_in = shift_ff + SW'(1);
               num_in   = num_ff << 1;
            end
         end
         cmsc_pkg::ST_DIVIDE: begin
            rem_in  = ge ? diff[FW-1:0] : rem_sh[FW-1:0];
            quot_in = {quot_ff[QW-2:0], ge};
            num_in  = num_ff << 1;
            cnt_in  = cnt_ff + cmsc_pkg::CNT_W'(1);
         end
         cmsc_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_active_in = !zero_ff;
               if (zero_ff) begin
                  rsp_mult_in  = '0;
                  rsp_shift_in = '0;
               end else begin
                  // Force the multiplier to at least 1.
                  rsp_mult_in  = (quot_ff == '0) ? QW'(1) : quot_ff;
                  rsp_shift_in = shift_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmsc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset needed.
   always_ff @(posedge clock) begin
      freq_ff       <= freq_in;
      zero_ff       <= zero_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      shift_ff      <= shift_in;
      cnt_ff        <= cnt_in;
      rsp_active_ff <= rsp_active_in;
      rsp_mult_ff   <= rsp_mult_in;
      rsp_shift_ff  <= rsp_shift_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_active      = rsp_active_ff;
   assign rsp_scale_mult  = rsp_mult_ff;
   assign rsp_scale_shift = rsp_shift_ff;

   // An active result always has a nonzero multiplier and a shift of at least 1.
   `CMSC_ASSERT_IMPL(a_active_fields, clock, reset, rsp_valid && rsp_active, (rsp_scale_mult != '0) && (rsp_scale_shift != '0))
   // An inactive result carries zero fields.
   `CMSC_ASSERT_IMPL(a_inactive_fields, clock, reset, rsp_valid && !rsp_active, (rsp_scale_mult == '0) && (rsp_scale_shift == '0))
   // The restoring divider keeps its remainder below the divisor.
   `CMSC_ASSERT_IMPL(a_rem_bound, clock, reset, state_ff == cmsc_pkg::ST_DIVIDE, rem_ff < freq_ff)
   // A zero frequency skips search and division.
   `CMSC_ASSERT_NEXT(a_zero_skip, clock, reset, req_accept && (req_freq_hz == '0), state_ff == cmsc_pkg::ST_DONE)

endmodule

// File: tb/clock_scale_checker.sv
// Channel monitor, scale-pair predictor and response scoreboard for clock_mult_shift_calc.
module clock_scale_checker #(
   parameter int unsigned FREQ_W = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [FREQ_W-1:0]             req_freq_hz,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_active,
   input  logic [cmsc_pkg::MULT_W-1:0]   rsp_scale_mult,
   input  logic [cmsc_pkg::SHIFT_W-1:0]  rsp_scale_shift,
   output int                            fail_count,
   output int                            open_count,
   output int                            req_count,
   output int                            rsp_count,
   output logic [63:0]                   shifts_hit
);

   typedef struct packed {
      logic                         active;
      logic [cmsc_pkg::MULT_W-1:0]  mult;
      logic [cmsc_pkg::SHIFT_W-1:0] shift;
   } scale_type;

   localparam logic [127:0] NS_PER_S = 128'd1000000000;

   scale_type expected_scales[$];

   // Largest shift whose multiplier fits in 32 bits, then the multiplier at that shift.
   // A shift overflows exactly when 10^9 << shift reaches freq << 32.
   function automatic scale_type predict_scale(input logic [FREQ_W-1:0] freq);
      scale_type    res;
      logic [127:0] freq_hi;
      logic [127:0] quot;
      int           sh;
      res = '0;
      if (freq != '0) begin
         freq_hi = 128'(freq) << 32;
         sh = 1;
         while (sh < 64 && (NS_PER_S << sh) < freq_hi) sh++;
         sh--;
         quot = (NS_PER_S << sh) / 128'(freq);
         if (quot == '0) quot = 128'd1;
         res.active = 1'b1;
         res.mult   = quot[cmsc_pkg::MULT_W-1:0];
         res.shift  = sh[cmsc_pkg::SHIFT_W-1:0];
      end
      return res;
   endfunction

   function automatic bit field_differs(input string field, input longint unsigned want,
                                        input longint unsigned seen);
      if (want != seen) begin
         $display("%0t checker: %s expected %0d, actual %0d", $time, field, want, seen);
      end
      return want != seen;
   endfunction

   always @(posedge clock) begin
      scale_type want_s;
      bit        bad;
      if (reset) begin
         expected_scales.delete();
         fail_count = 0;
         shifts_hit = '0;
         req_count  <= 0;
         rsp_count  <= 0;
         open_count <= 0;
      end else begin
         // retire the oldest expectation before queuing a new one
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (expected_scales.size() == 0) begin
               fail_count++;
               $display("%0t checker: response with no transaction waiting: %s",
                        $time, "expected none");
               $display("%0t checker: actual active %0d mult %0d shift %0d",
                        $time, rsp_active, rsp_scale_mult, rsp_scale_shift);
            end else begin
               want_s = expected_scales.pop_front();
               bad = 1'b0;
               bad |= field_differs("rsp_active", want_s.active, rsp_active);
               bad |= field_differs("rsp_scale_mult", want_s.mult, rsp_scale_mult);
               bad |= field_differs("rsp_scale_shift", want_s.shift, rsp_scale_shift);
               if (bad) fail_count++;
               if (want_s.active) shifts_hit[want_s.shift] = 1'b1;
            end
         end
         if (req_valid && !req_stall) begin
            expected_scales.push_back(predict_scale(req_freq_hz));
            req_count <= req_count + 1;
         end
         open_count <= expected_scales.size();
      end
   end

endmodule

// File: tb/tb_clock_mult_shift_calc.sv
// Testbench top for clock_mult_shift_calc: stimulus, flow control, watchdog and verdict.
module tb_clock_mult_shift_calc;

   localparam int unsigned FREQ_W       = 40;
   localparam int unsigned N_CORNER     = 22;
   localparam int unsigned N_RANDOM     = 1200;
   // worst item is a full search and division plus a long sender gap or receiver stall
   localparam int unsigned IDLE_LIMIT   = 4000;
   // extra idle time after the last expectation retires
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam logic [127:0] NS_1S       = 128'd1000000000;

   typedef enum int {GAP_NONE, GAP_SHORT, GAP_LONG} gap_mode_type;
   typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS} stall_mode_type;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_stall;
   logic [FREQ_W-1:0]                  req_freq_hz = '0;
   logic                               rsp_valid;
   logic                               rsp_stall   = 1'b0;
   logic                               rsp_active;
   logic [cmsc_pkg::MULT_W-1:0]        rsp_scale_mult;
   logic [cmsc_pkg::SHIFT_W-1:0]       rsp_scale_shift;

   int          fail_count;
   int          open_count;
   int          req_count;
   int          rsp_count;
   logic [63:0] shifts_hit;

   int           zero_sent  = 0;
   int           burst_left = 0;
   gap_mode_type gap_mode   = GAP_NONE;

   clock_mult_shift_calc #(
      .FREQ_WIDTH(FREQ_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_freq_hz    (req_freq_hz),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_active     (rsp_active),
      .rsp_scale_mult (rsp_scale_mult),
      .rsp_scale_shift(rsp_scale_shift)
   );

   // The checker sees the same pins as the block and keeps its own prediction.
   clock_scale_checker #(
      .FREQ_W(FREQ_W)
   ) scale_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_freq_hz    (req_freq_hz),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_active     (rsp_active),
      .rsp_scale_mult (rsp_scale_mult),
      .rsp_scale_shift(rsp_scale_shift),
      .fail_count     (fail_count),
      .open_count     (open_count),
      .req_count      (req_count),
      .rsp_count      (rsp_count),
      .shifts_hit     (shifts_hit)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Directed corner frequencies: zero, the smallest values, common crystal rates,
   // values around 10^9 and its power-of-two multiples where the chosen shift
   // changes, 32-bit edges, alternating bit patterns and the top of the range.
   function automatic logic [FREQ_W-1:0] corner_freq(input int idx);
      case (idx)
         0:       return '0;
         1:       return 40'd1;
         2:       return 40'd2;
         3:       return 40'd3;
         4:       return 40'd32768;
         5:       return 40'd19200000;
         6:       return 40'd24000000;
         7:       return 40'd999999999;
         8:       return 40'd1000000000;
         9:       return 40'd1000000001;
         10:      return 40'd2000000000;
         11:      return 40'd4294967295;
         12:      return 40'd4294967296;
         13:      return 40'd512000000000;
         14:      return 40'd1023999999999;
         15:      return 40'd1024000000000;
         16:      return 40'h5555555555;
         17:      return 40'hAAAAAAAAAA;
         18:      return 40'h8000000000;
         19:      return 40'hFFFFFFFFFF;
         20:      return 40'd500000000;
         21:      return 40'd7;
         default: return '0;
      endcase
   endfunction

   // Random frequency: full-range values (the largest share), then values of random magnitude,
   // values right at the boundaries where a shift starts to overflow, some zeros
   // and a few typical oscillator rates.
   function automatic logic [FREQ_W-1:0] random_freq();
      logic [FREQ_W-1:0] raw;
      logic [127:0]      bound_val;
      int                pick;
      int                width;
      raw  = {8'($urandom), 32'($urandom)};
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
         return raw;
      end else if (pick < 70) begin
         width = $urandom_range(FREQ_W, 1);
         return raw >> (FREQ_W - width);
      end else if (pick < 88) begin
         // freq near (10^9 << s) >> 32, nudged by -1..+2
         bound_val = (NS_1S << $urandom_range(42, 1)) >> 32;
         return FREQ_W'(bound_val + 128'($urandom_range(3, 0)) - 128'd1);
      end else if (pick < 94) begin
         return '0;
      end else begin
         case ($urandom_range(3, 0))
            0:       return 40'd32768;
            1:       return 40'd19200000;
            2:       return 40'd25000000;
            default: return 40'd100000000;
         endcase
      end
   endfunction

   // Send one transaction. Bursts of random length are separated by gaps whose size
   // depends on the current gap mode; valid is only dropped when a gap follows, so
   // back-to-back transactions keep it high without a second assignment in one step.
   task automatic send_freq(input logic [FREQ_W-1:0] freq);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(10, 1);
         case (gap_mode)
            GAP_NONE:  gap = 0;
            GAP_SHORT: gap = $urandom_range(12, 0);
            default:   gap = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 20)
                                                         : $urandom_range(40, 1);
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      if (freq == '0) zero_sent++;
      req_valid   <= 1'b1;
      req_freq_hz <= freq;
      // hold the payload until the block takes it
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver back-pressure: switch between no stall, coin-flip stall and long
   // stall runs, each held for a random span of cycles.
   initial begin
      stall_mode_type mode;
      int             span;
      forever begin
         mode = stall_mode_type'($urandom_range(2, 0));
         span = $urandom_range(400, 50);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_COIN: rsp_stall <= ($urandom_range(1, 0) == 1);
               default:    if ($urandom_range(11, 0) == 0) rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Watchdog: end the run once nothing has moved on either channel for too long.
   initial begin
      int idle     = 0;
      int last_req = 0;
      int last_rsp = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (req_count != last_req || rsp_count != last_rsp) begin
            idle     = 0;
            last_req = req_count;
            last_rsp = rsp_count;
         end else begin
            idle++;
         end
      end
      $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners first, a few gaps mixed in
      gap_mode = GAP_SHORT;
      for (int i = 0; i < N_CORNER; i++) send_freq(corner_freq(i));

      // random part; re-pick the gap mode every hundred transactions
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 100 == 0) gap_mode = gap_mode_type'($urandom_range(2, 0));
         send_freq(random_freq());
      end
      req_valid <= 1'b0;

      // drain: let the last expectation register, wait for it, then idle a while
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d requests sent (%0d zero frequency), %0d responses checked",
               req_count, zero_sent, rsp_count);
      $display("tb: %0d distinct shift values seen, %0d failing responses",
               $countones(shifts_hit), fail_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
